FILE: design/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// shared constants, types and helpers of the correlation and snr block
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COUNT_LOG2  = 20;
    localparam int SAMPLE_BITS = 16;

    // accumulator widths
    localparam int CNT_W  = COUNT_LOG2 + 1;
    localparam int SUM_W  = COUNT_LOG2 + SAMPLE_BITS;
    localparam int SQ_W   = COUNT_LOG2 + 2 * SAMPLE_BITS - 1;
    localparam int XY_W   = COUNT_LOG2 + 2 * SAMPLE_BITS;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SQI_W  = 2 * SAMPLE_BITS - 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << COUNT_LOG2;

    // back end widths
    localparam int VAR_W   = 2 * COUNT_LOG2 + 2 * SAMPLE_BITS - 1;
    localparam int CMAG_W  = VAR_W + 1;
    localparam int C_W     = VAR_W + 3;
    localparam int MUL_A_W = 176;
    localparam int MUL_B_W = CMAG_W;
    localparam int M_W     = 16;
    localparam int BIT_W   = 4;
    localparam int NUM_W   = 31;
    localparam int QUO_W   = NUM_W + 15;
    localparam int ITER_W  = 6;
    localparam int LOG_FRAC = 28;
    localparam int E_W     = 5;
    localparam int LOG_W   = E_W + LOG_FRAC;
    localparam int MANT_W  = 32;
    localparam int Q_SHIFT = 30;

    localparam logic [M_W-1:0]   M_ONE    = 16'h8000;
    localparam logic [NUM_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [31:0]      DB_K     = 32'd808071242;
    localparam logic [31:0]      SNR_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]      SNR_MIN  = 32'h8000_0000;
    localparam logic [ITER_W-1:0] DIV_STEPS = ITER_W'(QUO_W);
    localparam logic [ITER_W-1:0] LOG_STEPS = ITER_W'(LOG_FRAC);
    localparam logic [E_W-1:0]   E_TOP    = 5'd31;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = 1;
    localparam int LEVEL_W    = 2;

    // stream and register port
    localparam int IN_TDATA_W  = 2 * SAMPLE_BITS;
    localparam int OUT_TDATA_W = 72;
    localparam int STATUS_W    = 2;
    localparam int PADDR_W     = 3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    localparam logic REG_SNR_IN_DB = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [SQ_W-1:0]         sxx;
        logic [SQ_W-1:0]         syy;
        logic signed [XY_W-1:0]  sxy;
    } snap_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic signed [15:0]    rho;
        logic signed [31:0]    snr;
        logic [CNT_W-1:0]      pair_count;
        logic [STATUS_W-1:0]   status;
    } result_t;

    function automatic logic [SUM_W-1:0] mag_sum(input logic [SUM_W-1:0] v);
        mag_sum = v[SUM_W-1] ? SUM_W'(-v) : v;
    endfunction

    function automatic logic [XY_W-1:0] mag_xy(input logic [XY_W-1:0] v);
        mag_xy = v[XY_W-1] ? XY_W'(-v) : v;
    endfunction

endpackage

FILE: design/pearson_correlation_snr.sv
// flow: a last item is pushed into the sum queue in the cycle after acceptance; the
//   result time is set by the shared shift-add multiplier (16 rho search steps of up
//   to two multiplies each) and the 46-step divide or 2x28-step log; it is shorter
//   when the sums are small or a variance is zero
// throughput: one sample pair per cycle while the queue has room; one result per back-end run, two finished
//   snapshots may wait in the queue before the input stalls
// reset: rst_n clears the sums, count, queue, sequencer and snr_in_db (linear)
// ----------------------------------------------------------------------------
// pearson_correlation_snr
// pearson correlation and snr of paired sample streams, stream in and out,
// register port for the snr format
// ----------------------------------------------------------------------------
module pearson_correlation_snr
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [pcs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // sample_x, sample_y
    input  logic                                  s_axis_tlast,  // last_pair
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pcs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // rho, snr, pair_count
    output logic [pcs_pkg::STATUS_W-1:0]          m_axis_tuser,  // status
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pcs_pkg::PADDR_W-1:0]           paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import pcs_pkg::*;

    logic               snr_in_db_reg;
    logic               cfg_wr;

    logic               push;
    snap_t              push_data;
    logic               pop;
    snap_t              pop_data;
    logic [LEVEL_W-1:0] fifo_level;
    logic               avail;
    result_t            res;

    // register port: single register, selected when address bit 2 is zero, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snr_in_db_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[2] == REG_SNR_IN_DB)
        begin
            snr_in_db_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_SNR_IN_DB) ? {31'b0, snr_in_db_reg} : '0;

    // front: products then running sums, snapshot on the last item
    pcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample_x   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .sample_y   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .last_pair  (s_axis_tlast),
        .fifo_level (fifo_level),
        .push       (push),
        .push_data  (push_data)
    );

    // queue of finished sums so the input keeps moving during a back-end run
    pcs_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .level     (fifo_level),
        .avail     (avail)
    );

    // back: variances, covariance, rho search, snr and the result register
    pcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .snap      (pop_data),
        .pop       (pop),
        .snr_in_db (snr_in_db_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // rho in the low bits, then snr, then pair_count, zero padded
    assign m_axis_tdata = {3'b0, res.pair_count, res.snr, res.rho};
    assign m_axis_tuser = res.status;

endmodule

FILE: design/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// takes sample pairs, keeps the running sums, hands a snapshot on the last item
// ----------------------------------------------------------------------------
module pcs_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pcs_pkg::SAMPLE_BITS-1:0] sample_x,
    input  logic signed [pcs_pkg::SAMPLE_BITS-1:0] sample_y,
    input  logic                                last_pair,
    input  logic [pcs_pkg::LEVEL_W-1:0]         fifo_level,
    output logic                                push,
    output pcs_pkg::snap_t                      push_data
);
    import pcs_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg, s1_y_reg;
    logic [SQI_W-1:0]        s1_xx_reg, s1_yy_reg;
    logic signed [PROD_W-1:0] s1_xy_reg;
    logic signed [PROD_W-1:0] xx_full, yy_full, xy_full;

    logic [CNT_W-1:0]        count_reg, count_next, acc_n;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, acc_x;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next, acc_y;
    logic [SQ_W-1:0]         sum_xx_reg, sum_xx_next, acc_xx;
    logic [SQ_W-1:0]         sum_yy_reg, sum_yy_next, acc_yy;
    logic signed [XY_W-1:0]  sum_xy_reg, sum_xy_next, acc_xy;
    logic [LEVEL_W:0]        pending;

    // room for every last item already taken in
    assign pending  = {1'b0, fifo_level} + (LEVEL_W+1)'(s1_valid_reg & s1_last_reg);
    assign in_ready = pending < (LEVEL_W+1)'(FIFO_DEPTH);

    assign xx_full = sample_x * sample_x;
    assign yy_full = sample_y * sample_y;
    assign xy_full = sample_x * sample_y;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid & in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_last_reg <= last_pair;
            s1_x_reg    <= sample_x;
            s1_y_reg    <= sample_y;
            s1_xx_reg   <= xx_full[SQI_W-1:0];
            s1_yy_reg   <= yy_full[SQI_W-1:0];
            s1_xy_reg   <= xy_full;
        end
    end

    // accumulate stage, pairs past the full count are dropped
    always_comb
    begin
        acc_n  = count_reg;
        acc_x  = sum_x_reg;
        acc_y  = sum_y_reg;
        acc_xx = sum_xx_reg;
        acc_yy = sum_yy_reg;
        acc_xy = sum_xy_reg;
        if (count_reg < CNT_MAX)
        begin
            acc_n  = count_reg + CNT_W'(1);
            acc_x  = sum_x_reg + SUM_W'(s1_x_reg);
            acc_y  = sum_y_reg + SUM_W'(s1_y_reg);
            acc_xx = sum_xx_reg + SQ_W'(s1_xx_reg);
            acc_yy = sum_yy_reg + SQ_W'(s1_yy_reg);
            acc_xy = sum_xy_reg + XY_W'(s1_xy_reg);
        end

        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_yy_next = sum_yy_reg;
        sum_xy_next = sum_xy_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                count_next  = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
                sum_xx_next = '0;
                sum_yy_next = '0;
                sum_xy_next = '0;
            end
            else
            begin
                count_next  = acc_n;
                sum_x_next  = acc_x;
                sum_y_next  = acc_y;
                sum_xx_next = acc_xx;
                sum_yy_next = acc_yy;
                sum_xy_next = acc_xy;
            end
        end
    end

    assign push      = s1_valid_reg & s1_last_reg;
    assign push_data = '{n: acc_n, sx: acc_x, sy: acc_y, sxx: acc_xx, syy: acc_yy,
                         sxy: acc_xy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xx_reg <= sum_xx_next;
            sum_yy_reg <= sum_yy_next;
            sum_xy_reg <= sum_xy_next;
        end
    end

endmodule

FILE: design/pcs_fifo.sv
// ----------------------------------------------------------------------------
// pcs_fifo
// short queue of sum snapshots between the front and the back
// ----------------------------------------------------------------------------
module pcs_fifo
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  pcs_pkg::snap_t              push_data,
    input  logic                        pop,
    output pcs_pkg::snap_t              pop_data,
    output logic [pcs_pkg::LEVEL_W-1:0] level,
    output logic                        avail
);
    import pcs_pkg::*;

    snap_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + LEVEL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            level_reg <= level_next;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign level    = level_reg;
    assign avail    = level_reg != '0;

endmodule

FILE: design/pcs_mul.sv
// ----------------------------------------------------------------------------
// pcs_mul
// shift-add multiplier, one bit of the second operand per cycle
// ----------------------------------------------------------------------------
module pcs_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcs_pkg::mul_req_t           req,
    output logic                        done,
    output logic [pcs_pkg::MUL_A_W-1:0] prod
);
    import pcs_pkg::*;

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_A_W-1:0] acc_reg;
    logic               run_reg;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg && b_reg == '0)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (run_reg && b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: design/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// sequencer for variances, covariance, rho search, snr divide and log, output register
// ----------------------------------------------------------------------------
module pcs_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                avail,
    input  pcs_pkg::snap_t      snap,
    output logic                pop,
    input  logic                snr_in_db,
    output logic                out_valid,
    input  logic                out_ready,
    output pcs_pkg::result_t    out_data
);
    import pcs_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_VXA   = 20'h00002,
        S_VXB   = 20'h00004,
        S_VYA   = 20'h00008,
        S_VYB   = 20'h00010,
        S_CA    = 20'h00020,
        S_CB    = 20'h00040,
        S_PM    = 20'h00080,
        S_QM    = 20'h00100,
        S_CAND  = 20'h00200,
        S_CSQ   = 20'h00400,
        S_TM    = 20'h00800,
        S_SNR   = 20'h01000,
        S_NUM   = 20'h02000,
        S_DIV   = 20'h04000,
        S_DEND  = 20'h08000,
        S_LNORM = 20'h10000,
        S_LSQ   = 20'h20000,
        S_DBM   = 20'h40000,
        S_FIN   = 20'h80000
    } state_t;

    state_t              state_reg, state_next;
    snap_t               snap_reg, snap_next;
    logic [MUL_A_W-1:0]  t1_reg, t1_next;
    logic [VAR_W-1:0]    vx_reg, vx_next, vy_reg, vy_next;
    logic                cneg_reg, cneg_next;
    logic [CMAG_W-1:0]   cmag_reg, cmag_next;
    logic [MUL_A_W-1:0]  p_reg, p_next, q_reg, q_next;
    logic [M_W-1:0]      m_reg, m_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [31:0]         snr_reg, snr_next;
    logic [NUM_W-1:0]    den_reg, den_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [31:0]         lv_reg, lv_next;
    logic [E_W-1:0]      e_reg, e_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic [LOG_W-1:0]    ln_reg, ln_next;
    logic                log_sel_reg, log_sel_next;
    logic                neg_reg, neg_next;
    logic                out_valid_reg;
    result_t             out_reg;

    mul_req_t            mreq;
    logic                mul_done;
    logic [MUL_A_W-1:0]  mul_prod;

    logic [M_W-1:0]      cand;
    logic [C_W-1:0]      ca, cb, cval;
    logic                sa, sb;
    logic [NUM_W:0]      trial;
    logic                ge;
    logic [63:0]         sq;
    logic [MANT_W:0]     sqs;
    logic [LOG_FRAC-1:0] frac_new;
    logic [LOG_W-1:0]    lval, dmag;
    logic [63:0]         rnd;
    logic [23:0]         rdb;
    logic                load;
    logic [15:0]         rho_val;

    pcs_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign cand = m_reg | (M_W'(1) << bit_reg);

    // signed covariance from the two magnitude products
    assign sa   = snap_reg.sxy[XY_W-1];
    assign sb   = snap_reg.sx[SUM_W-1] ^ snap_reg.sy[SUM_W-1];
    assign ca   = sa ? C_W'(-C_W'(t1_reg[VAR_W-1:0])) : C_W'(t1_reg[VAR_W-1:0]);
    assign cb   = sb ? C_W'(-C_W'(mul_prod[VAR_W-1:0])) : C_W'(mul_prod[VAR_W-1:0]);
    assign cval = ca - cb;

    // restoring divide step
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // log step: square the mantissa, renormalize
    assign sq       = 64'(mant_reg) * 64'(mant_reg);
    assign sqs      = sq[63:31];
    assign frac_new = {frac_reg[LOG_FRAC-2:0], sqs[MANT_W]};
    assign lval     = {e_reg, frac_new};
    assign dmag     = (ln_reg < lval) ? lval - ln_reg : ln_reg - lval;

    assign rnd = mul_prod[63:0] + (64'(1) << 39);
    assign rdb = rnd[63:40];

    assign load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (cneg_reg)
        begin
            rho_val = 16'(-m_reg);
        end
        else if (m_reg > 16'h7FFF)
        begin
            rho_val = 16'h7FFF;
        end
        else
        begin
            rho_val = m_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        snap_next    = snap_reg;
        t1_next      = t1_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        cneg_next    = cneg_reg;
        cmag_next    = cmag_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        m_next       = m_reg;
        bit_next     = bit_reg;
        status_next  = status_reg;
        snr_next     = snr_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        iter_next    = iter_reg;
        lv_next      = lv_reg;
        e_next       = e_reg;
        mant_next    = mant_reg;
        frac_next    = frac_reg;
        ln_next      = ln_reg;
        log_sel_next = log_sel_reg;
        neg_next     = neg_reg;
        mreq         = '{start: 1'b0, a: '0, b: '0};
        pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop         = 1'b1;
                    snap_next   = snap;
                    m_next      = '0;
                    cneg_next   = 1'b0;
                    status_next = ST_OK;
                    snr_next    = '0;
                    mreq        = '{start: 1'b1, a: MUL_A_W'(snap.sxx), b: MUL_B_W'(snap.n)};
                    state_next  = S_VXA;
                end
            end
            S_VXA:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_prod;
                    mreq       = '{start: 1'b1, a: MUL_A_W'(mag_sum(snap_reg.sx)),
                                   b: MUL_B_W'(mag_sum(snap_reg.sx))};
                    state_next = S_VXB;
                end
            end
            S_VXB:
            begin
                if (mul_done)
                begin
                    if (t1_reg > mul_prod)
                    begin
                        vx_next    = VAR_W'(t1_reg - mul_prod);
                        mreq       = '{start: 1'b1, a: MUL_A_W'(snap_reg.syy),
                                       b: MUL_B_W'(snap_reg.n)};
                        state_next = S_VYA;
                    end
                    else
                    begin
                        status_next = ST_ZERO_VAR;
                        state_next  = S_FIN;
                    end
                end
            end
            S_VYA:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_prod;
                    mreq       = '{start: 1'b1, a: MUL_A_W'(mag_sum(snap_reg.sy)),
                                   b: MUL_B_W'(mag_sum(snap_reg.sy))};
                    state_next = S_VYB;
                end
            end
            S_VYB:
            begin
                if (mul_done)
                begin
                    if (t1_reg > mul_prod)
                    begin
                        vy_next    = VAR_W'(t1_reg - mul_prod);
                        mreq       = '{start: 1'b1, a: MUL_A_W'(mag_xy(snap_reg.sxy)),
                                       b: MUL_B_W'(snap_reg.n)};
                        state_next = S_CA;
                    end
                    else
                    begin
                        status_next = ST_ZERO_VAR;
                        state_next  = S_FIN;
                    end
                end
            end
            S_CA:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_prod;
                    mreq       = '{start: 1'b1, a: MUL_A_W'(mag_sum(snap_reg.sx)),
                                   b: MUL_B_W'(mag_sum(snap_reg.sy))};
                    state_next = S_CB;
                end
            end
            S_CB:
            begin
                if (mul_done)
                begin
                    cneg_next  = cval[C_W-1];
                    cmag_next  = cval[C_W-1] ? CMAG_W'(-cval) : CMAG_W'(cval);
                    mreq       = '{start: 1'b1, a: MUL_A_W'(vx_reg), b: MUL_B_W'(vy_reg)};
                    state_next = S_PM;
                end
            end
            S_PM:
            begin
                if (mul_done)
                begin
                    p_next     = mul_prod;
                    mreq       = '{start: 1'b1, a: MUL_A_W'(cmag_reg), b: cmag_reg};
                    state_next = S_QM;
                end
            end
            S_QM:
            begin
                if (mul_done)
                begin
                    q_next     = mul_prod << Q_SHIFT;
                    bit_next   = BIT_W'(M_W - 1);
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                if (cand > M_ONE)
                begin
                    if (bit_reg == '0)
                    begin
                        state_next = S_SNR;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_W'(1);
                    end
                end
                else
                begin
                    mreq       = '{start: 1'b1, a: MUL_A_W'(cand), b: MUL_B_W'(cand)};
                    state_next = S_CSQ;
                end
            end
            S_CSQ:
            begin
                if (mul_done)
                begin
                    mreq       = '{start: 1'b1, a: p_reg, b: MUL_B_W'(mul_prod[31:0])};
                    state_next = S_TM;
                end
            end
            S_TM:
            begin
                if (mul_done)
                begin
                    if (mul_prod <= q_reg)
                    begin
                        m_next = cand;
                    end
                    if (bit_reg == '0)
                    begin
                        state_next = S_SNR;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = S_CAND;
                    end
                end
            end
            S_SNR:
            begin
                if (m_reg >= M_ONE)
                begin
                    snr_next    = SNR_MAX;
                    status_next = ST_SAT;
                    state_next  = S_FIN;
                end
                else if (snr_in_db && m_reg == '0)
                begin
                    snr_next    = SNR_MIN;
                    status_next = ST_SAT;
                    state_next  = S_FIN;
                end
                else
                begin
                    mreq       = '{start: 1'b1, a: MUL_A_W'(m_reg), b: MUL_B_W'(m_reg)};
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                if (mul_done)
                begin
                    den_next = ONE_Q30 - mul_prod[NUM_W-1:0];
                    if (snr_in_db)
                    begin
                        lv_next      = 32'(mul_prod[NUM_W-1:0]);
                        e_next       = E_TOP;
                        log_sel_next = 1'b0;
                        state_next   = S_LNORM;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = {mul_prod[NUM_W-2:0], 16'b0};
                        iter_next  = DIV_STEPS;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? NUM_W'(trial - {1'b0, den_reg}) : trial[NUM_W-1:0];
                quo_next  = {quo_reg[QUO_W-2:0], ge};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = S_DEND;
                end
            end
            S_DEND:
            begin
                if (quo_reg[QUO_W-1:31] != '0)
                begin
                    snr_next    = SNR_MAX;
                    status_next = ST_SAT;
                end
                else
                begin
                    snr_next = quo_reg[31:0];
                end
                state_next = S_FIN;
            end
            S_LNORM:
            begin
                if (lv_reg[31])
                begin
                    mant_next  = lv_reg;
                    frac_next  = '0;
                    iter_next  = LOG_STEPS;
                    state_next = S_LSQ;
                end
                else
                begin
                    lv_next = lv_reg << 1;
                    e_next  = e_reg - E_W'(1);
                end
            end
            S_LSQ:
            begin
                frac_next = frac_new;
                mant_next = sqs[MANT_W] ? sqs[MANT_W:1] : sqs[MANT_W-1:0];
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    if (!log_sel_reg)
                    begin
                        ln_next      = lval;
                        log_sel_next = 1'b1;
                        lv_next      = 32'(den_reg);
                        e_next       = E_TOP;
                        state_next   = S_LNORM;
                    end
                    else
                    begin
                        neg_next   = ln_reg < lval;
                        mreq       = '{start: 1'b1, a: MUL_A_W'(dmag), b: MUL_B_W'(DB_K)};
                        state_next = S_DBM;
                    end
                end
            end
            S_DBM:
            begin
                if (mul_done)
                begin
                    snr_next   = neg_reg ? 32'(-32'(rdb)) : 32'(rdb);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg    <= snap_next;
        t1_reg      <= t1_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        cneg_reg    <= cneg_next;
        cmag_reg    <= cmag_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        m_reg       <= m_next;
        bit_reg     <= bit_next;
        status_reg  <= status_next;
        snr_reg     <= snr_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        iter_reg    <= iter_next;
        lv_reg      <= lv_next;
        e_reg       <= e_next;
        mant_reg    <= mant_next;
        frac_reg    <= frac_next;
        ln_reg      <= ln_next;
        log_sel_reg <= log_sel_next;
        neg_reg     <= neg_next;
        if (load)
        begin
            out_reg <= '{rho: rho_val, snr: snr_reg, pair_count: snap_reg.n,
                         status: status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE) && avail)
        else $error("snapshot taken while busy");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_VXA) || (state_reg == S_VXB) || (state_reg == S_VYA) ||
                     (state_reg == S_VYB) || (state_reg == S_CA) || (state_reg == S_CB) ||
                     (state_reg == S_PM) || (state_reg == S_QM) || (state_reg == S_CSQ) ||
                     (state_reg == S_TM) || (state_reg == S_NUM) || (state_reg == S_DBM))
        else $error("multiplier result with no one waiting");

    a_zero_var_out: assert property (@(posedge clk) disable iff (!rst_n)
        load && (status_reg == ST_ZERO_VAR) |=> (out_reg.rho == '0) && (out_reg.snr == '0))
        else $error("zero variance result not cleared");

    a_rho_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SNR) |-> (m_reg <= M_ONE))
        else $error("rho magnitude above one");
`endif

endmodule
